// File: hw/rtl/assert_macros.svh
// Assertion macros used by the checker module of the line-follower block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is high.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that is checked during reset as well.
`define ASSERT_CLK_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: hw/rtl/tslf_pkg.sv
// Types and constants shared by the three-sensor line-follower PID modules.
`timescale 1ns / 1ps

package tslf_pkg;

  localparam int LEVEL_W    = 17;
  localparam int GAIN_W     = 24;
  localparam int CFG_DATA_W = 24;
  localparam int CFG_IDX_W  = 3;
  localparam int ERR_W      = 18;
  localparam int DIFF_W     = 19;
  localparam int SUM_W      = 32;
  localparam int MUL_A_W    = 25;
  localparam int MUL_B_W    = 32;
  localparam int PROD_W     = MUL_A_W + MUL_B_W;
  localparam int ACC_W      = 58;
  localparam int FRAC_W     = 16;
  localparam int PID16_W    = ACC_W - FRAC_W;
  localparam int SPLIT_W    = 21;
  localparam int SPEED_W    = 32;
  localparam int WIDE_W     = 44;

  localparam logic [LEVEL_W-1:0] Q16_ONE     = 17'd65536;
  localparam logic [ACC_W-1:0]   ROUND_HALF  = 58'd32768;
  localparam logic [MUL_A_W-1:0] TURN_SCALE  = 25'd11432;

  localparam logic [GAIN_W-1:0]  KP_RESET       = 24'd983040;
  localparam logic [GAIN_W-1:0]  KD_RESET       = 24'd65536;
  localparam logic [GAIN_W-1:0]  KI_RESET       = 24'd655;
  localparam logic [GAIN_W-1:0]  BASE_RESET     = 24'hFEF40E;
  localparam logic [LEVEL_W-1:0] MARGIN_RESET   = 17'd23593;
  localparam logic [LEVEL_W-1:0] DEADBAND_RESET = 17'd3277;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GAIN_P   = 3'd0,
    REG_GAIN_D   = 3'd1,
    REG_GAIN_I   = 3'd2,
    REG_BASE     = 3'd3,
    REG_MARGIN   = 3'd4,
    REG_DEADBAND = 3'd5
  } cfg_reg_t;

  typedef enum logic [2:0] {
    MUL_P,
    MUL_D,
    MUL_I,
    MUL_HI,
    MUL_LO
  } mul_sel_t;

  typedef struct packed {
    logic     capture;
    logic     update;
    mul_sel_t mul_sel;
    logic     mul_en;
    logic     acc_load;
    logic     acc_load_shift;
    logic     acc_add;
    logic     pid_round;
    logic     corr_round;
    logic     corr_clear;
    logic     out_load;
  } cmd_t;

  typedef struct packed {
    logic sample_ok;
    logic over_deadband;
  } status_t;

endpackage

// File: hw/rtl/tslf_ctrl.sv
// Sequencing state machine of the line-follower PID block.
`timescale 1ns / 1ps

module tslf_ctrl import tslf_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    s_tvalid,
  output logic    s_tready,
  output logic    m_tvalid,
  input  logic    m_tready,
  input  status_t status,
  output cmd_t    cmd
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DECIDE,
    ST_MUL_P,
    ST_MUL_D,
    ST_MUL_I,
    ST_ACC_I,
    ST_RND_PID,
    ST_MUL_HI,
    ST_MUL_LO,
    ST_ACC_LO,
    ST_RND_CORR,
    ST_WRITE
  } state_t;

  state_t state;
  logic   out_free;

  assign s_tready = (state == ST_IDLE);
  assign out_free = !m_tvalid || m_tready;

  always_comb begin
    cmd = '0;
    cmd.mul_sel = MUL_P;
    case (state)
      ST_IDLE: begin
        cmd.capture = s_tvalid;
      end
      ST_CHECK: begin
        cmd.update = status.sample_ok;
      end
      ST_DECIDE: begin
        cmd.corr_clear = !status.over_deadband;
      end
      ST_MUL_P: begin
        cmd.mul_sel = MUL_P;
        cmd.mul_en  = 1'b1;
      end
      ST_MUL_D: begin
        cmd.mul_sel  = MUL_D;
        cmd.mul_en   = 1'b1;
        cmd.acc_load = 1'b1;
      end
      ST_MUL_I: begin
        cmd.mul_sel = MUL_I;
        cmd.mul_en  = 1'b1;
        cmd.acc_add = 1'b1;
      end
      ST_ACC_I: begin
        cmd.acc_add = 1'b1;
      end
      ST_RND_PID: begin
        cmd.pid_round = 1'b1;
      end
      ST_MUL_HI: begin
        cmd.mul_sel = MUL_HI;
        cmd.mul_en  = 1'b1;
      end
      ST_MUL_LO: begin
        cmd.mul_sel        = MUL_LO;
        cmd.mul_en         = 1'b1;
        cmd.acc_load_shift = 1'b1;
      end
      ST_ACC_LO: begin
        cmd.acc_add = 1'b1;
      end
      ST_RND_CORR: begin
        cmd.corr_round = 1'b1;
      end
      ST_WRITE: begin
        cmd.out_load = out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      if (cmd.out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (s_tvalid) state <= ST_CHECK;
        end
        ST_CHECK: begin
          state <= status.sample_ok ? ST_DECIDE : ST_IDLE;
        end
        ST_DECIDE: begin
          state <= status.over_deadband ? ST_MUL_P : ST_WRITE;
        end
        ST_MUL_P:    state <= ST_MUL_D;
        ST_MUL_D:    state <= ST_MUL_I;
        ST_MUL_I:    state <= ST_ACC_I;
        ST_ACC_I:    state <= ST_RND_PID;
        ST_RND_PID:  state <= ST_MUL_HI;
        ST_MUL_HI:   state <= ST_MUL_LO;
        ST_MUL_LO:   state <= ST_ACC_LO;
        ST_ACC_LO:   state <= ST_RND_CORR;
        ST_RND_CORR: state <= ST_WRITE;
        ST_WRITE: begin
          if (out_free) state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

// File: hw/rtl/tslf_datapath.sv
// Datapath of the line-follower PID block: registers, shared multiplier, accumulator.
`timescale 1ns / 1ps

module tslf_datapath import tslf_pkg::*; (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [CFG_IDX_W-1:0]       cfg_index,
  input  logic [CFG_DATA_W-1:0]      cfg_data,
  input  logic [LEVEL_W-1:0]         left_level,
  input  logic [LEVEL_W-1:0]         middle_level,
  input  logic [LEVEL_W-1:0]         right_level,
  input  cmd_t                       cmd,
  output status_t                    status,
  output logic signed [SPEED_W-1:0]  left_speed,
  output logic signed [SPEED_W-1:0]  right_speed,
  output logic signed [1:0]          side_sign
);

  // Configuration registers.
  logic [GAIN_W-1:0]  gain_p;
  logic [GAIN_W-1:0]  gain_d;
  logic [GAIN_W-1:0]  gain_i;
  logic [GAIN_W-1:0]  base_speed;
  logic [LEVEL_W-1:0] line_margin;
  logic [LEVEL_W-1:0] deadband;

  // Captured sample.
  logic [LEVEL_W-1:0] lvl_l;
  logic [LEVEL_W-1:0] lvl_m;
  logic [LEVEL_W-1:0] lvl_r;

  // Loop state.
  logic signed [ERR_W-1:0] last_error;
  logic signed [SUM_W-1:0] error_sum;
  logic                    first_sample;

  // Working registers.
  logic signed [ERR_W-1:0]   err;
  logic signed [DIFF_W-1:0]  diff;
  logic signed [1:0]         sign;
  logic signed [PROD_W-1:0]  prod;
  logic signed [ACC_W-1:0]   acc;
  logic signed [PID16_W-1:0] pid16;
  logic signed [PID16_W-1:0] corr;

  logic [LEVEL_W-1:0]        d_mid;
  logic signed [DIFF_W-1:0]  err_wide;
  logic signed [ERR_W-1:0]   err_now;
  logic signed [DIFF_W-1:0]  diff_now;
  logic signed [SUM_W:0]     sum_wide;
  logic signed [SUM_W-1:0]   sum_next;
  logic signed [1:0]         sign_now;
  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [SPLIT_W-1:0] pid_hi;
  logic [ACC_W-1:0]          acc_rnd;
  logic signed [WIDE_W-1:0]  base_wide;
  logic signed [WIDE_W-1:0]  corr_wide;
  logic signed [WIDE_W-1:0]  spd_plus;
  logic signed [WIDE_W-1:0]  spd_minus;
  logic signed [WIDE_W-1:0]  left_wide;
  logic signed [WIDE_W-1:0]  right_wide;

  function automatic logic level_ok(input logic [LEVEL_W-1:0] lvl);
    level_ok = (lvl != '0) && !lvl[LEVEL_W-1];
  endfunction

  function automatic logic signed [SPEED_W-1:0] sat_speed(input logic signed [WIDE_W-1:0] v);
    logic signed [WIDE_W-1:0] hi_lim;
    logic signed [WIDE_W-1:0] lo_lim;
    hi_lim = WIDE_W'({1'b0, {(SPEED_W-1){1'b1}}});
    lo_lim = -hi_lim - WIDE_W'(1);
    if (v > hi_lim) begin
      sat_speed = {1'b0, {(SPEED_W-1){1'b1}}};
    end else if (v < lo_lim) begin
      sat_speed = {1'b1, {(SPEED_W-1){1'b0}}};
    end else begin
      sat_speed = v[SPEED_W-1:0];
    end
  endfunction

  // Darkness of the middle sensor and the error against the margin.
  assign d_mid    = Q16_ONE - lvl_m;
  assign err_wide = signed'({2'b00, line_margin}) - signed'({2'b00, d_mid});
  assign err_now  = err_wide[ERR_W-1:0];
  assign diff_now = first_sample ? '0 :
                    signed'({last_error[ERR_W-1], last_error}) -
                    signed'({err_now[ERR_W-1], err_now});

  // Left darker means a lower left level.
  assign sign_now = (lvl_l < lvl_r) ? 2'sb01 : ((lvl_l > lvl_r) ? 2'sb11 : 2'sb00);

  assign sum_wide = signed'({error_sum[SUM_W-1], error_sum}) + (SUM_W+1)'(err_now);
  always_comb begin
    if (sum_wide[SUM_W] != sum_wide[SUM_W-1]) begin
      sum_next = sum_wide[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
    end else begin
      sum_next = sum_wide[SUM_W-1:0];
    end
  end

  assign status.sample_ok     = level_ok(lvl_l) && level_ok(lvl_m) && level_ok(lvl_r);
  assign status.over_deadband = signed'({err[ERR_W-1], err}) > signed'({2'b00, deadband});

  // Operand selection for the shared 25 x 32 signed multiplier.
  assign pid_hi = pid16[PID16_W-1:SPLIT_W];
  always_comb begin
    case (cmd.mul_sel)
      MUL_P: begin
        mul_a = signed'({1'b0, gain_p});
        mul_b = MUL_B_W'(err);
      end
      MUL_D: begin
        mul_a = signed'({1'b0, gain_d});
        mul_b = MUL_B_W'(diff);
      end
      MUL_I: begin
        mul_a = signed'({1'b0, gain_i});
        mul_b = error_sum;
      end
      MUL_HI: begin
        mul_a = signed'(TURN_SCALE);
        mul_b = MUL_B_W'(pid_hi);
      end
      MUL_LO: begin
        mul_a = signed'(TURN_SCALE);
        mul_b = signed'({{(MUL_B_W-SPLIT_W){1'b0}}, pid16[SPLIT_W-1:0]});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign acc_rnd = acc + ROUND_HALF;

  // Wheel speeds from base and signed correction.
  assign base_wide = WIDE_W'(signed'(base_speed));
  assign corr_wide = WIDE_W'(corr);
  assign spd_plus  = base_wide + corr_wide;
  assign spd_minus = base_wide - corr_wide;
  always_comb begin
    case (sign)
      2'sb01: begin
        left_wide  = spd_plus;
        right_wide = spd_minus;
      end
      2'sb11: begin
        left_wide  = spd_minus;
        right_wide = spd_plus;
      end
      default: begin
        left_wide  = base_wide;
        right_wide = base_wide;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      gain_p       <= KP_RESET;
      gain_d       <= KD_RESET;
      gain_i       <= KI_RESET;
      base_speed   <= BASE_RESET;
      line_margin  <= MARGIN_RESET;
      deadband     <= DEADBAND_RESET;
      last_error   <= '0;
      error_sum    <= '0;
      first_sample <= 1'b1;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_GAIN_P:   gain_p      <= cfg_data[GAIN_W-1:0];
          REG_GAIN_D:   gain_d      <= cfg_data[GAIN_W-1:0];
          REG_GAIN_I:   gain_i      <= cfg_data[GAIN_W-1:0];
          REG_BASE:     base_speed  <= cfg_data[GAIN_W-1:0];
          REG_MARGIN:   line_margin <= cfg_data[LEVEL_W-1:0];
          REG_DEADBAND: deadband    <= cfg_data[LEVEL_W-1:0];
          default: ;
        endcase
      end
      if (cmd.update) begin
        last_error   <= err_now;
        first_sample <= 1'b0;
        if (!first_sample) error_sum <= sum_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      lvl_l <= left_level;
      lvl_m <= middle_level;
      lvl_r <= right_level;
    end
    if (cmd.update) begin
      err  <= err_now;
      diff <= diff_now;
      sign <= sign_now;
    end
    if (cmd.mul_en) prod <= mul_a * mul_b;
    if (cmd.acc_load) begin
      acc <= ACC_W'(prod);
    end else if (cmd.acc_load_shift) begin
      acc <= ACC_W'(prod) <<< SPLIT_W;
    end else if (cmd.acc_add) begin
      acc <= acc + ACC_W'(prod);
    end
    if (cmd.pid_round) pid16 <= signed'(acc_rnd[ACC_W-1:FRAC_W]);
    if (cmd.corr_clear) begin
      corr <= '0;
    end else if (cmd.corr_round) begin
      corr <= signed'(acc_rnd[ACC_W-1:FRAC_W]);
    end
    if (cmd.out_load) begin
      left_speed  <= sat_speed(left_wide);
      right_speed <= sat_speed(right_wide);
      side_sign   <= sign;
    end
  end

endmodule

// File: hw/rtl/three_sensor_line_follow_pid.sv
// Top level of the three-sensor line-follower PID controller.
`timescale 1ns / 1ps

// Three-sensor line-following PID controller. Each input beat carries the
// left, middle and right sensor intensities in Q1.16. The block inverts the
// middle one to a darkness value; a sample with any reading of zero, or of
// 1.0 or more, is dropped without a result and without touching the loop
// state. A valid sample yields exactly one output beat with the left and
// right wheel speeds (signed Q15.16, saturated to 32 bits) and the side
// sign (+1 when the left sensor is darker, -1 when the right one is, 0 when
// equal). The correction base +/- sign * 0.17444 * (Kp*e + Kd*(e_prev -
// e) + Ki*sum(e)) is applied only when the error exceeds the deadband;
// otherwise both wheels get the base speed. The block handles one sample at
// a time. A sample above the deadband uses the single shared 25 x 32
// multiplier five times in turn (three PID terms and two halves of the turn
// scaling) before its result reaches the output register; one within the
// deadband goes straight to the output register, and a dropped sample opens
// the input again after the check. The next input beat is taken as soon as
// the result sits in the output register, even while the downstream side
// has not yet taken it; a held output only stalls the block when a second
// result is ready. Gains, base speed, line margin and deadband are to be
// written through the plain register port (index 0..5 in that order; other
// indexes are ignored) while the block is idle, which it does not enforce.
module three_sensor_line_follow_pid import tslf_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  // Configuration write port.
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  // Input stream.
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [55:0]           s_tdata,   // left_level, middle_level, right_level, 5'b0
  // Output stream.
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [71:0]           m_tdata    // left_speed, right_speed, side_sign, 6'b0
);

  cmd_t    cmd;
  status_t status;

  logic signed [SPEED_W-1:0] left_speed;
  logic signed [SPEED_W-1:0] right_speed;
  logic signed [1:0]         side_sign;

  // The controller only sequences; all arithmetic and data storage sits in the datapath.
  tslf_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .status   (status),
    .cmd      (cmd)
  );

  tslf_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .left_level   (s_tdata[16:0]),
    .middle_level (s_tdata[33:17]),
    .right_level  (s_tdata[50:34]),
    .cmd          (cmd),
    .status       (status),
    .left_speed   (left_speed),
    .right_speed  (right_speed),
    .side_sign    (side_sign)
  );

  // Output beat: fields packed from bit 0 up, zero padding to a whole byte.
  assign m_tdata = {6'b0, side_sign, right_speed, left_speed};

endmodule

// File: hw/rtl/tslf_checker.sv
// Port-level assertion checker for the line-follower PID block, with its bind.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module tslf_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [71:0] m_tdata
);

  // Reset leaves no result pending.
  `ASSERT_CLK_ALWAYS(a_reset_empty, clk, rst |=> !m_tvalid, "output valid after reset")

  // One sample at a time: an accepted beat closes the input for the next cycle.
  `ASSERT_CLK(a_one_at_a_time, clk, rst, (s_tvalid && s_tready) |=> !s_tready, "input open after accept")

  // A stalled result holds its payload.
  `ASSERT_CLK(a_out_hold, clk, rst, (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)), "output changed while stalled")

  // Side sign is -1, 0 or +1, and with no side both wheels run the same speed.
  `ASSERT_CLK(a_sign_code, clk, rst, m_tvalid |-> (m_tdata[65:64] != 2'b10), "bad side sign")
  `ASSERT_CLK(a_equal_wheels, clk, rst, (m_tvalid && (m_tdata[65:64] == 2'b00)) |-> (m_tdata[31:0] == m_tdata[63:32]), "wheels differ with no side")

endmodule

bind three_sensor_line_follow_pid tslf_checker u_checker (.*);
